// ----- src/assert_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CCP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccp assertion failed");

// Delayed implication: the consequence is checked after the antecedent, disabled while reset is high.
`define CCP_ASSERT_DLY2(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("ccp assertion failed");

`endif

// ----- src/ccp_pkg.sv -----
package ccp_pkg;

  localparam int SLOT_W = 6;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_INSERT = 3'd0;
  localparam cmd_t CMD_REMOVE = 3'd1;
  localparam cmd_t CMD_ACCESS = 3'd2;
  localparam cmd_t CMD_PIN    = 3'd3;
  localparam cmd_t CMD_EVICT  = 3'd4;

  localparam status_t STATUS_OK     = 2'd0;
  localparam status_t STATUS_EMPTY  = 2'd1;
  localparam status_t STATUS_PINNED = 2'd2;

  typedef struct packed {
    logic in_use;
    logic pinned;
    logic referenced;
  } flags_t;

endpackage

// ----- src/ccp_flag_ram.sv -----
module ccp_flag_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  ccp_pkg::flags_t wdata,
  input  logic [AW-1:0]   raddr,
  output ccp_pkg::flags_t rdata
);
  import ccp_pkg::*;

  flags_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/clock_page_replacement.sv -----
// Clock (second-chance) victim selector. A command is taken when start is high and busy is
// low; its result is shown on the result ports for one cycle with done high and cannot be
// stalled. The per-slot flags live in a single-port-write, registered-read memory, and every
// command but an eviction on an empty table goes through it: insert, remove, mark accessed
// and set pin read their slot as they are accepted and write it back in ST_CMD, where the
// result is registered. An eviction on an empty table answers straight from ST_IDLE;
// otherwise the sweep visits one slot per cycle through the memory read port, for at most
// 2 * FRAME_SLOTS visits. After reset, busy stays high while a clearing pass zeroes the flags.
module clock_page_replacement #(
  parameter int FRAME_SLOTS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  ccp_pkg::cmd_t               cmd,
  input  logic [ccp_pkg::SLOT_W-1:0]  slot,
  input  logic                        pin_value,
  output logic                        busy,
  output logic                        done,
  output logic                        victim_found,
  output logic [ccp_pkg::SLOT_W-1:0]  victim_slot,
  output ccp_pkg::status_t            status
);
  import ccp_pkg::*;

  localparam int AW = $clog2(FRAME_SLOTS);
  localparam int CW = $clog2(FRAME_SLOTS + 1);
  localparam int VW = $clog2(2 * FRAME_SLOTS);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CMD   = 4'b0100,
    ST_SWEEP = 4'b1000
  } state_t;

  state_t        state;
  logic [AW-1:0] hand;
  logic [CW-1:0] count;
  logic [AW-1:0] clr_ptr;
  logic [AW-1:0] chk_ptr;
  logic [VW-1:0] visits;
  cmd_t          cmd_r;
  logic [AW-1:0] addr_r;
  logic          valid_r;
  logic          pin_r;

  logic          accept;
  logic          slot_ok;
  logic [AW-1:0] slot_addr;
  logic [AW-1:0] next_chk;
  logic          hit;
  logic          cnt_inc;
  logic          cnt_dec;
  logic          we;
  logic [AW-1:0] waddr;
  flags_t        wdata;
  logic [AW-1:0] raddr;
  flags_t        rdata;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(FRAME_SLOTS - 1)) ? '0 : p + AW'(1);
  endfunction

  ccp_flag_ram #(
    .DEPTH (FRAME_SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign slot_ok   = (32'(slot) < FRAME_SLOTS);
  assign slot_addr = AW'(32'(slot));
  assign next_chk  = advance(chk_ptr);
  assign hit       = (state == ST_SWEEP) && rdata.in_use && !rdata.pinned && !rdata.referenced;

  always_comb begin
    raddr   = slot_addr;
    we      = 1'b0;
    waddr   = chk_ptr;
    wdata   = '0;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_ptr;
      end
      ST_IDLE: begin
        if (cmd == CMD_EVICT) begin
          raddr = hand;
        end
      end
      ST_CMD: begin
        waddr = addr_r;
        if (valid_r) begin
          case (cmd_r)
            CMD_INSERT: begin
              if (!rdata.in_use) begin
                we      = 1'b1;
                wdata   = '{in_use: 1'b1, pinned: 1'b0, referenced: 1'b0};
                cnt_inc = 1'b1;
              end
            end
            CMD_REMOVE: begin
              we      = 1'b1;
              cnt_dec = rdata.in_use;
            end
            CMD_ACCESS: begin
              we    = rdata.in_use;
              wdata = '{in_use: 1'b1, pinned: rdata.pinned, referenced: 1'b1};
            end
            CMD_PIN: begin
              we    = rdata.in_use;
              wdata = '{in_use: 1'b1, pinned: pin_r, referenced: rdata.referenced};
            end
            default: begin
              we = 1'b0;
            end
          endcase
        end
      end
      ST_SWEEP: begin
        raddr = next_chk;
        // A referenced frame loses its bit and survives; an unreferenced one is evicted.
        if (rdata.in_use && !rdata.pinned) begin
          we = 1'b1;
          if (rdata.referenced) begin
            wdata = '{in_use: 1'b1, pinned: 1'b0, referenced: 1'b0};
          end else begin
            cnt_dec = 1'b1;
          end
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      hand    <= '0;
      count   <= '0;
      clr_ptr <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cnt_inc) begin
        count <= count + CW'(1);
      end else if (cnt_dec) begin
        count <= count - CW'(1);
      end
      case (state)
        ST_CLEAR: begin
          clr_ptr <= clr_ptr + AW'(1);
          if (clr_ptr == AW'(FRAME_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd;
            addr_r  <= slot_addr;
            valid_r <= slot_ok;
            pin_r   <= pin_value;
            if (cmd == CMD_EVICT) begin
              if (count == '0) begin
                done         <= 1'b1;
                victim_found <= 1'b0;
                victim_slot  <= '0;
                status       <= STATUS_EMPTY;
              end else begin
                state   <= ST_SWEEP;
                chk_ptr <= hand;
                visits  <= '0;
              end
            end else begin
              state <= ST_CMD;
            end
          end
        end
        ST_CMD: begin
          done         <= 1'b1;
          victim_found <= 1'b0;
          victim_slot  <= '0;
          status       <= STATUS_OK;
          state        <= ST_IDLE;
        end
        ST_SWEEP: begin
          chk_ptr <= next_chk;
          visits  <= visits + VW'(1);
          if (hit) begin
            done         <= 1'b1;
            victim_found <= 1'b1;
            victim_slot  <= SLOT_W'(32'(chk_ptr));
            status       <= STATUS_OK;
            hand         <= next_chk;
            state        <= ST_IDLE;
          end else if (visits == VW'(2 * FRAME_SLOTS - 1)) begin
            // Two full passes without a candidate: every frame in use is pinned.
            done         <= 1'b1;
            victim_found <= 1'b0;
            victim_slot  <= '0;
            status       <= STATUS_PINNED;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/ccp_checker.sv -----
`include "assert_macros.svh"

module ccp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input ccp_pkg::cmd_t               cmd,
  input logic                        done,
  input logic                        victim_found,
  input logic [ccp_pkg::SLOT_W-1:0]  victim_slot,
  input ccp_pkg::status_t            status
);
  import ccp_pkg::*;

  // A chosen victim always reports success.
  `CCP_ASSERT_IMP(a_found_ok, clk, rst, done && victim_found, status == STATUS_OK)

  // Without a victim the slot field reads zero.
  `CCP_ASSERT_IMP(a_nofound_zero, clk, rst, done && !victim_found, victim_slot == '0)

  // Plain commands raise done once they have passed through ST_CMD after acceptance.
  `CCP_ASSERT_DLY2(a_cmd_latency, clk, rst, start && !busy && cmd != CMD_EVICT, done)

  // An empty-table answer follows directly on an accepted item.
  `CCP_ASSERT_IMP(a_empty_fast, clk, rst, done && status == STATUS_EMPTY,
                  $past(start && !busy))

endmodule

bind clock_page_replacement ccp_checker u_ccp_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .cmd          (cmd),
  .done         (done),
  .victim_found (victim_found),
  .victim_slot  (victim_slot),
  .status       (status)
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ccp_pkg::*;

  localparam int FRAME_SLOTS = 64;
  localparam int SETTLE_CYCLES = 2 * FRAME_SLOTS + 8;
  localparam int unsigned CYCLE_LIMIT = 1_200_000;

  // Command codes that the block does not define.
  localparam cmd_t CMD_RESERVED_FIRST = 3'd5;
  localparam cmd_t CMD_RESERVED_LAST  = 3'd7;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot_idx;
    status_t           code;
  } frame_result_t;

  logic              clk;
  logic              rst;
  logic              start;
  cmd_t              cmd;
  logic [SLOT_W-1:0] slot;
  logic              pin_value;
  logic              busy;
  logic              done;
  logic              victim_found;
  logic [SLOT_W-1:0] victim_slot;
  status_t           status;

  // Predicted frame table.
  logic [FRAME_SLOTS-1:0] frame_used;
  logic [FRAME_SLOTS-1:0] frame_pinned;
  logic [FRAME_SLOTS-1:0] frame_ref;
  logic [SLOT_W-1:0]      sweep_hand;

  frame_result_t pending_results[$];
  frame_result_t oldest;
  int            mismatch_count;
  bit            gaps_on;
  int unsigned   cycle_count;

  clock_page_replacement #(.FRAME_SLOTS(FRAME_SLOTS)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .slot         (slot),
    .pin_value    (pin_value),
    .busy         (busy),
    .done         (done),
    .victim_found (victim_found),
    .victim_slot  (victim_slot),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Updates the predicted table for one command and returns its result.
  function automatic frame_result_t apply_frame_command(cmd_t c, logic [SLOT_W-1:0] s,
                                                        logic pv);
    frame_result_t     r;
    logic [SLOT_W-1:0] p;
    bit                chosen;
    int                i;
    r = '0;
    r.code = STATUS_OK;
    case (c)
      CMD_INSERT: begin
        if (!frame_used[s]) begin
          frame_used[s] = 1'b1;
          frame_pinned[s] = 1'b0;
          frame_ref[s] = 1'b0;
        end
      end
      CMD_REMOVE: begin
        frame_used[s] = 1'b0;
        frame_pinned[s] = 1'b0;
        frame_ref[s] = 1'b0;
      end
      CMD_ACCESS: begin
        if (frame_used[s]) frame_ref[s] = 1'b1;
      end
      CMD_PIN: begin
        if (frame_used[s]) frame_pinned[s] = pv;
      end
      CMD_EVICT: begin
        if (frame_used == '0) begin
          r.code = STATUS_EMPTY;
        end else begin
          // Two full passes; a referenced frame loses its bit on the first visit.
          r.code = STATUS_PINNED;
          p = sweep_hand;
          chosen = 1'b0;
          for (i = 0; i < 2 * FRAME_SLOTS && !chosen; i++) begin
            if (frame_used[p] && !frame_pinned[p]) begin
              if (frame_ref[p]) begin
                frame_ref[p] = 1'b0;
              end else begin
                frame_used[p] = 1'b0;
                frame_pinned[p] = 1'b0;
                frame_ref[p] = 1'b0;
                sweep_hand = p + 1'b1;
                r.found = 1'b1;
                r.slot_idx = p;
                r.code = STATUS_OK;
                chosen = 1'b1;
              end
            end
            p = p + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Sends one item and records its predicted result once it is taken. Start is left high,
  // so the caller either sends again or lowers it in the same step.
  task automatic issue_command(cmd_t c, logic [SLOT_W-1:0] s, logic pv);
    if (gaps_on && $urandom_range(99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    slot <= s;
    pin_value <= pv;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_frame_command(c, s, pv));
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual found %0d slot %0d status %0d",
                 $time, victim_found, victim_slot, status);
        mismatch_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (victim_found !== oldest.found) begin
          $display("%0t: victim_found expected %0d actual %0d", $time, oldest.found,
                   victim_found);
          mismatch_count++;
        end
        if (victim_slot !== oldest.slot_idx) begin
          $display("%0t: victim_slot expected %0d actual %0d", $time, oldest.slot_idx,
                   victim_slot);
          mismatch_count++;
        end
        if (status !== oldest.code) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.code, status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_evict_empty_table();
    issue_command(CMD_EVICT, 6'd0, 1'b0);
  endtask

  // A lone referenced frame gets its second chance and the hand wraps back onto it.
  task automatic test_single_frame_wrap();
    issue_command(CMD_REMOVE, 6'd5, 1'b0);
    issue_command(CMD_INSERT, 6'd63, 1'b0);
    issue_command(CMD_ACCESS, 6'd63, 1'b0);
    issue_command(CMD_EVICT, 6'd63, 1'b1);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
  endtask

  task automatic test_pin_rules();
    issue_command(CMD_ACCESS, 6'd7, 1'b0);
    issue_command(CMD_PIN, 6'd7, 1'b1);
    issue_command(CMD_INSERT, 6'd0, 1'b0);
    issue_command(CMD_PIN, 6'd0, 1'b1);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
    issue_command(CMD_PIN, 6'd0, 1'b0);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
  endtask

  task automatic test_reserved_codes();
    issue_command(CMD_RESERVED_FIRST, 6'd42, 1'b1);
    issue_command(cmd_t'(CMD_RESERVED_FIRST + 3'd1), 6'd21, 1'b0);
    issue_command(CMD_RESERVED_LAST, 6'd63, 1'b1);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
  endtask

  // A second insert must keep the reference bit, so the first eviction passes over slot 10.
  task automatic test_second_chance();
    issue_command(CMD_INSERT, 6'd10, 1'b0);
    issue_command(CMD_ACCESS, 6'd10, 1'b0);
    issue_command(CMD_INSERT, 6'd10, 1'b0);
    issue_command(CMD_INSERT, 6'd33, 1'b0);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
    issue_command(CMD_EVICT, 6'd0, 1'b0);
  endtask

  // Mixed traffic over a window of slots that changes every few dozen items. Narrow windows
  // keep the table crowded so that collisions, full pinning and long sweeps come up.
  task automatic test_random_traffic(int count);
    int                sent;
    int                roll;
    int                span;
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] s;
    cmd_t              c;
    logic              pv;
    sent = 0;
    span = FRAME_SLOTS;
    base = '0;
    while (sent < count) begin
      if (sent % 40 == 0) begin
        roll = $urandom_range(2);
        span = (roll == 0) ? 4 : (roll == 1) ? 16 : FRAME_SLOTS;
        base = SLOT_W'($urandom_range(FRAME_SLOTS - 1));
      end
      s = base + SLOT_W'($urandom_range(span - 1));
      pv = ($urandom_range(99) < 45);
      roll = $urandom_range(99);
      if (roll < 30) c = CMD_INSERT;
      else if (roll < 46) c = CMD_ACCESS;
      else if (roll < 56) c = CMD_PIN;
      else if (roll < 66) c = CMD_REMOVE;
      else if (roll < 96) c = CMD_EVICT;
      else c = cmd_t'($urandom_range(CMD_RESERVED_LAST, CMD_RESERVED_FIRST));
      issue_command(c, s, pv);
      if (c <= CMD_EVICT) sent++;
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[clock_page_replacement] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSERT;
    slot = '0;
    pin_value = 1'b0;
    frame_used = '0;
    frame_pinned = '0;
    frame_ref = '0;
    sweep_hand = '0;
    mismatch_count = 0;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_evict_empty_table();
    test_single_frame_wrap();
    test_pin_rules();
    test_reserved_codes();
    test_second_chance();

    test_random_traffic(700);
    gaps_on = 1'b0;
    test_random_traffic(300);
    gaps_on = 1'b1;
    wait_results_drained();
    test_random_traffic(830);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_results.size() != 0) begin
      oldest = pending_results.pop_front();
      $display("%0t: missing result: expected found %0d slot %0d status %0d, actual none",
               $time, oldest.found, oldest.slot_idx, oldest.code);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[clock_page_replacement] OK");
    end else begin
      $display("[clock_page_replacement] ERROR");
    end
    $finish;
  end

endmodule

// ----- clock_page_replacement.f -----
+incdir+src
src/ccp_pkg.sv
src/ccp_flag_ram.sv
src/clock_page_replacement.sv
src/ccp_checker.sv
verif/testbench.sv
